### design/lob_pkg.sv
// ----------------------------------------------------------------------------
// lob_pkg: shared types and constants of the order book
// status codes, field widths, the payload structs of both channels and the cell structs
// ----------------------------------------------------------------------------
package lob_pkg;

  localparam int unsigned MaxOrdersDef = 64;
  localparam int unsigned IdW          = 64;
  localparam int unsigned PriceW       = 32;
  localparam int unsigned SharesW      = 32;
  localparam int unsigned VolW         = 38;

  typedef enum logic [1:0] {
    ST_DONE       = 2'd0,
    ST_NOT_FOUND  = 2'd1,
    ST_FULL       = 2'd2,
    ST_ZERO_PRICE = 2'd3
  } status_e;

  typedef enum logic {
    REQ_ADD  = 1'b0,
    REQ_EXEC = 1'b1
  } req_e;

  typedef struct packed {
    logic               req_type;
    logic               side;
    logic [IdW-1:0]     ord_ref;
    logic [PriceW-1:0]  price;
    logic [SharesW-1:0] shares;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              book_changed;
    logic              bid_present;
    logic [PriceW-1:0] best_bid;
    logic              ask_present;
    logic [PriceW-1:0] best_ask;
    logic [VolW-1:0]   bid_volume;
    logic [VolW-1:0]   ask_volume;
    logic [VolW:0]     imbalance;
  } rsp_t;

  // one order entry as held by a cell
  typedef struct packed {
    logic               vld;
    logic               side;
    logic [PriceW-1:0]  price;
    logic [IdW-1:0]     id;
    logic [SharesW-1:0] shares;
  } entry_t;

  // running aggregate that travels through the chain of cells
  typedef struct packed {
    logic              bid_any;
    logic [PriceW-1:0] best_bid;
    logic              ask_any;
    logic [PriceW-1:0] best_ask;
    logic [VolW-1:0]   bid_vol;
    logic [VolW-1:0]   ask_vol;
  } agg_t;

endpackage

### design/lob_if.sv
// ----------------------------------------------------------------------------
// lob_req_if / lob_rsp_if: valid-ready channels of the order book
// payload is carried as one packed struct
// ----------------------------------------------------------------------------
interface lob_req_if;
  logic          valid;
  logic          ready;
  lob_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lob_rsp_if;
  logic          valid;
  logic          ready;
  lob_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### design/lob_cell.sv
// ----------------------------------------------------------------------------
// lob_cell: one order slot of the book
// matches, updates and shifts its entry and folds it into the aggregate
// ----------------------------------------------------------------------------
module lob_cell (
  input  logic                clk_i,
  input  lob_pkg::entry_t     upper_i,   // entry of the next younger cell
  input  logic                first_i,   // this is the append slot
  input  logic                match_ph_i,
  input  logic                add_i,
  input  lob_pkg::req_t       req_i,
  input  logic                found_i,   // a matching entry was met upstream
  output logic                found_o,
  input  lob_pkg::agg_t       agg_i,
  output lob_pkg::agg_t       agg_o,     // registered, one cell per cycle
  input  logic                shift_i,   // a removal at or below this cell
  input  logic                rm_here_i,
  input  logic                rst_vld_i,
  output lob_pkg::entry_t     entry_o,
  output logic                hit_o
);

  lob_pkg::entry_t e_q, e_d;
  logic            vld_q;
  logic            hit;
  logic [lob_pkg::SharesW-1:0] rem;
  lob_pkg::agg_t   agg_q, agg_d;

  assign hit = e_q.vld && vld_q && !found_i && e_q.side == req_i.side
               && e_q.price == req_i.price && e_q.id == req_i.ord_ref;
  assign hit_o   = hit;
  assign found_o = found_i | hit;
  assign rem = (e_q.shares > req_i.shares) ? e_q.shares - req_i.shares : '0;

  always_comb begin
    agg_d = agg_i;
    if (vld_q) begin
      if (!e_q.side) begin
        if (!agg_i.bid_any || e_q.price > agg_i.best_bid) agg_d.best_bid = e_q.price;
        agg_d.bid_any = 1'b1;
        agg_d.bid_vol = agg_i.bid_vol + lob_pkg::VolW'(e_q.shares);
      end else begin
        if (!agg_i.ask_any || e_q.price < agg_i.best_ask) agg_d.best_ask = e_q.price;
        agg_d.ask_any = 1'b1;
        agg_d.ask_vol = agg_i.ask_vol + lob_pkg::VolW'(e_q.shares);
      end
    end
  end

  assign agg_o = agg_q;

  always_comb begin
    e_d = e_q;
    if (add_i && first_i) begin
      e_d = '{vld: 1'b1, side: req_i.side, price: req_i.price,
              id: req_i.ord_ref, shares: req_i.shares};
    end else if (match_ph_i && hit) begin
      e_d.shares = rem;
    end else if (shift_i && !rm_here_i) begin
      e_d = upper_i;
    end else if (rm_here_i) begin
      e_d = upper_i;
    end
  end

  assign entry_o = '{vld: vld_q, side: e_q.side, price: e_q.price,
                     id: e_q.id, shares: e_q.shares};

  always_ff @(posedge clk_i) begin
    e_q <= e_d;
  end

  // valid bit and aggregate stage are reset, the entry payload is not
  always_ff @(posedge clk_i or negedge rst_vld_i) begin
    if (!rst_vld_i) begin
      vld_q <= 1'b0;
      agg_q <= '0;
    end else begin
      vld_q <= e_d.vld && (add_i && first_i ? 1'b1 : (shift_i || rm_here_i) ? upper_i.vld : vld_q);
      agg_q <= agg_d;
    end
  end

endmodule

### design/limit_order_book_top.sv
// ----------------------------------------------------------------------------
// limit_order_book_top: resting order table with best bid and ask
// chain of order cells with a sequencer per event
// ----------------------------------------------------------------------------
// usage
//   req channel: one event per transfer (add or execute, side, id, price,
//   shares). rsp channel: exactly one result per event, in order.
//   each event runs as: accept, match/append in every cell at once, removal
//   shift (the younger entries move down one cell), then a summary pass in
//   which the bid/ask aggregate moves one cell per cycle through registered
//   cell stages. the summary pass ends when the aggregate has passed every
//   cell stage, so the length of the cell chain sets its length. the result
//   is held in the output register; a new event is taken only once the
//   previous one is through its summary pass and the sequencer is idle.
//   reset clears the cell valid bits, the aggregate stages and the
//   sequencer: the book is empty and ready as soon as reset is released.
//   a stalled receiver holds the result in the output register; the next
//   event is still taken and runs up to the end of its summary pass, where
//   it waits until the held result has been transferred.
// ----------------------------------------------------------------------------
module limit_order_book_top #(
  parameter int unsigned MAX_ORDERS = lob_pkg::MaxOrdersDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  lob_req_if.sink   req,
  lob_rsp_if.source rsp
);

  localparam int unsigned CntW = $clog2(MAX_ORDERS + 1);

  typedef enum logic [1:0] {S_IDLE, S_MATCH, S_SHIFT, S_SUM} state_e;

  state_e               state_q;
  lob_pkg::req_t        req_q;
  logic [CntW-1:0]      cnt_q;
  logic [CntW-1:0]      sum_cnt_q; // progress of the summary pass, stops at MAX_ORDERS
  logic [1:0]           status_q;
  logic                 chg_q;
  logic                 rm_q;      // removal pending in the shift step
  logic [MAX_ORDERS-1:0] rm_pos_q; // one-hot cell to remove
  logic                 rsp_vld_q;
  lob_pkg::rsp_t        rsp_q;

  lob_pkg::entry_t      ent [MAX_ORDERS+1];
  lob_pkg::agg_t        agg [MAX_ORDERS+1];
  logic [MAX_ORDERS:0]  found;
  logic [MAX_ORDERS-1:0] hit;
  logic [MAX_ORDERS-1:0] shift;
  logic                 do_add;
  logic                 rm_now;    // the hit entry runs out of shares
  logic                 sum_done;

  assign req.ready = (state_q == S_IDLE);
  assign ent[MAX_ORDERS] = '0;
  assign agg[0] = '0;
  assign found[0] = 1'b0;

  // append happens in the match step when the event is a legal add
  assign do_add = (state_q == S_MATCH) && req_q.req_type == lob_pkg::REQ_ADD
                  && req_q.price != '0 && cnt_q < CntW'(MAX_ORDERS);

  // the hit cell's new count is zero when shares cover it
  always_comb begin
    rm_now = 1'b0;
    for (int i = 0; i < MAX_ORDERS; i++)
      if (hit[i]) rm_now = !(ent[i].shares > req_q.shares);
  end

  // cells at and above the removed one take their upper neighbor
  always_comb begin
    logic acc;
    acc = 1'b0;
    for (int i = 0; i < MAX_ORDERS; i++) begin
      acc      = acc | (rm_q && rm_pos_q[i]);
      shift[i] = acc;
    end
  end

  for (genvar g = 0; g < MAX_ORDERS; g++) begin : g_cell
    lob_cell u_cell (
      .clk_i      (clk_i),
      .upper_i    (ent[g+1]),
      .first_i    (cnt_q == CntW'(g)),
      .match_ph_i (state_q == S_MATCH && req_q.req_type == lob_pkg::REQ_EXEC),
      .add_i      (do_add),
      .req_i      (req_q),
      .found_i    (found[g]),
      .found_o    (found[g+1]),
      .agg_i      (agg[g]),
      .agg_o      (agg[g+1]),
      .shift_i    (state_q == S_SHIFT && shift[g]),
      .rm_here_i  (1'b0),
      .rst_vld_i  (rst_ni),
      .entry_o    (ent[g]),
      .hit_o      (hit[g])
    );
  end

  lob_pkg::agg_t fin;
  assign fin = agg[MAX_ORDERS];

  // aggregate has reached the last stage and the output register is free
  assign sum_done = (state_q == S_SUM) && (sum_cnt_q == CntW'(MAX_ORDERS))
                    && (!rsp_vld_q || rsp.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      req_q     <= '0;
      cnt_q     <= '0;
      sum_cnt_q <= '0;
      status_q  <= lob_pkg::ST_DONE;
      chg_q     <= 1'b0;
      rm_q      <= 1'b0;
      rm_pos_q  <= '0;
      rsp_vld_q <= 1'b0;
      rsp_q     <= '0;
    end else begin
      if (sum_done) rsp_vld_q <= 1'b1;
      else if (rsp.valid && rsp.ready) rsp_vld_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            req_q   <= req.data;
            state_q <= S_MATCH;
          end
        end
        S_MATCH: begin
          rm_pos_q <= hit;
          rm_q     <= (req_q.req_type == lob_pkg::REQ_EXEC) && rm_now;
          chg_q    <= do_add || (req_q.req_type == lob_pkg::REQ_EXEC && |hit);
          if (req_q.req_type == lob_pkg::REQ_ADD) begin
            if (req_q.price == '0) status_q <= lob_pkg::ST_ZERO_PRICE;
            else if (!do_add) status_q <= lob_pkg::ST_FULL;
            else begin
              status_q <= lob_pkg::ST_DONE;
              cnt_q    <= cnt_q + CntW'(1);
            end
          end else if (|hit) begin
            status_q <= lob_pkg::ST_DONE;
          end else begin
            status_q <= lob_pkg::ST_NOT_FOUND;
          end
          state_q <= S_SHIFT;
        end
        S_SHIFT: begin
          if (rm_q) cnt_q <= cnt_q - CntW'(1);
          rm_q      <= 1'b0;
          sum_cnt_q <= '0;
          state_q   <= S_SUM;
        end
        S_SUM: begin
          if (sum_cnt_q != CntW'(MAX_ORDERS)) sum_cnt_q <= sum_cnt_q + CntW'(1);
          if (sum_done) begin
            rsp_q.status       <= status_q;
            rsp_q.book_changed <= chg_q;
            rsp_q.bid_present  <= fin.bid_any;
            rsp_q.best_bid     <= fin.best_bid;
            rsp_q.ask_present  <= fin.ask_any;
            rsp_q.best_ask     <= fin.best_ask;
            rsp_q.bid_volume   <= fin.bid_vol;
            rsp_q.ask_volume   <= fin.ask_vol;
            rsp_q.imbalance    <= {1'b0, fin.bid_vol} - {1'b0, fin.ask_vol};
            state_q            <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid = rsp_vld_q;
  assign rsp.data  = rsp_q;

  // a stalled result holds its payload
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.data)))
    else $error("result dropped or changed while stalled");
  // only one event in flight
  a_one_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req.valid && req.ready) |=> !req.ready) else $error("second event taken");
  // book occupancy never exceeds the table
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MAX_ORDERS)) else $error("count overflow");

endmodule
